/* design/sisc_pkg.sv */
// shared types, constants and segment font for the signed integer display driver
`timescale 1ns / 1ps
package sisc_pkg;

   localparam int MAG_W      = 32;
   localparam int IDX_W      = 4;
   localparam int SEG_W      = 8;
   localparam int ND_W       = 3;
   localparam int PP_W       = 3;
   localparam int SL_W       = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIGITS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_POSITION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGN_LIMIT     = 2'd2;

   localparam logic [ND_W-1:0] NUM_DIGITS_RESET     = 3'd3;
   localparam logic [PP_W-1:0] POINT_POSITION_RESET = 3'd2;
   localparam logic [SL_W-1:0] SIGN_LIMIT_RESET     = 4'd3;

   localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;
   localparam logic [SEG_W-1:0] MINUS_SEG = 8'h01;
   localparam logic [SEG_W-1:0] BLANK_SEG = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic done;
      logic sticky;
   } bcd_status_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic             sticky;
      logic [IDX_W-1:0] num_digits;
      logic [IDX_W-1:0] point_pos;
      logic [IDX_W-1:0] sign_limit;
   } emit_ctrl_type;

   typedef struct packed {
      logic busy;
   } emit_status_type;

   function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
      logic [SEG_W-1:0] seg;
      unique case (digit)
         4'd0:    seg = 8'h7e;
         4'd1:    seg = 8'h30;
         4'd2:    seg = 8'h6d;
         4'd3:    seg = 8'h79;
         4'd4:    seg = 8'h33;
         4'd5:    seg = 8'h5b;
         4'd6:    seg = 8'h5f;
         4'd7:    seg = 8'h70;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h7b;
         default: seg = BLANK_SEG;
      endcase
      return seg;
   endfunction

endpackage

/* design/sisc_bcd.sv */
// bit-serial binary to bcd converter, one magnitude bit per cycle
`timescale 1ns / 1ps
module sisc_bcd #(
   parameter int MAX_DIGITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sisc_pkg::MAG_W-1:0]    magnitude,
   output logic [4*MAX_DIGITS-1:0]       bcd,
   output sisc_pkg::bcd_status_type      status
);
   import sisc_pkg::*;

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int CNT_W = $clog2(MAG_W);

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] adj;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic             sticky_ff, sticky_in;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int j = 0; j < MAX_DIGITS; j++) begin
         adj[4*j +: 4] = (bcd_ff[4*j +: 4] >= 4'd5) ? bcd_ff[4*j +: 4] + 4'd3
                                                      : bcd_ff[4*j +: 4];
      end
   end

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      sticky_in  = sticky_ff;
      if (start) begin
         mag_in     = magnitude;
         bcd_in     = '0;
         cnt_in     = '0;
         running_in = 1'b1;
         sticky_in  = 1'b0;
      end else if (running_ff) begin
         mag_in    = {mag_ff[MAG_W-2:0], 1'b0};
         bcd_in    = {adj[BCD_W-2:0], mag_ff[MAG_W-1]};
         // a bit carried out of the top digit means digits beyond the display
         sticky_in = sticky_ff | adj[BCD_W-1];
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      mag_ff    <= mag_in;
      bcd_ff    <= bcd_in;
      cnt_ff    <= cnt_in;
      sticky_ff <= sticky_in;
   end

   assign bcd           = bcd_ff;
   assign status.done   = done_ff;
   assign status.sticky = sticky_ff;

endmodule

/* design/sisc_emit.sv */
// command sequencer: shifts out one bcd digit per command into the output register
`timescale 1ns / 1ps
module sisc_emit #(
   parameter int MAX_DIGITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sisc_pkg::emit_ctrl_type             ctrl,
   input  logic [4*MAX_DIGITS-1:0]             bcd,
   output sisc_pkg::emit_status_type           status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sisc_pkg::IDX_W-1:0]          rsp_digit_address,
   output logic [sisc_pkg::SEG_W-1:0]          rsp_segment_data,
   output logic                                rsp_last
);
   import sisc_pkg::*;

   localparam int BCD_W = 4 * MAX_DIGITS;

   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             active_ff, active_in;
   logic             stopped_ff, stopped_in;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic             last_ff, last_in;
   logic             advance;
   logic             rem_nz;
   logic             is_last;

   assign advance = active_ff && (!valid_ff || !rsp_stall);
   assign rem_nz  = ctrl.sticky || (bcd_ff != '0);
   assign is_last = (idx_ff == ctrl.num_digits - 1'b1);

   always_comb begin
      bcd_in     = bcd_ff;
      idx_in     = idx_ff;
      active_in  = active_ff;
      stopped_in = stopped_ff;
      valid_in   = valid_ff && rsp_stall;
      addr_in    = addr_ff;
      seg_in     = seg_ff;
      last_in    = last_ff;
      if (ctrl.start) begin
         bcd_in     = bcd;
         idx_in     = '0;
         active_in  = 1'b1;
         stopped_in = 1'b0;
      end else if (advance) begin
         valid_in = 1'b1;
         addr_in  = ctrl.num_digits - idx_ff;
         last_in  = is_last;
         idx_in   = idx_ff + 1'b1;
         bcd_in   = bcd_ff >> 4;
         priority if (!stopped_ff && (idx_ff <= ctrl.point_pos || rem_nz)) begin
            seg_in = seg_font(bcd_ff[3:0]);
            if (idx_ff == ctrl.point_pos) begin
               seg_in = seg_in | POINT_BIT;
            end
         end else if (!stopped_ff) begin
            // first position past the digits may carry the minus
            stopped_in = 1'b1;
            seg_in     = (ctrl.neg && idx_ff < ctrl.sign_limit) ? MINUS_SEG : BLANK_SEG;
         end else begin
            seg_in = BLANK_SEG;
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      bcd_ff     <= bcd_in;
      idx_ff     <= idx_in;
      stopped_ff <= stopped_in;
      addr_ff    <= addr_in;
      seg_ff     <= seg_in;
      last_ff    <= last_in;
   end

   assign status.busy       = active_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_digit_address = addr_ff;
   assign rsp_segment_data  = seg_ff;
   assign rsp_last          = last_ff;

   // the final command always lands on the lowest driver address
   a_last_addr_one: assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> addr_ff == 4'd1)
      else $error("last command not at address one");

   a_addr_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> addr_ff != '0)
      else $error("command at address zero");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> active_ff && idx_ff == '0 && !stopped_ff)
      else $error("sequencer did not load on start");

   a_busy_no_start: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !ctrl.start)
      else $error("start while sequencer busy");

endmodule

/* design/signed_int_to_segment_commands.sv */
// top level: configuration registers, item control and converter/sequencer hookup
// an accepted item is converted to bcd first, then its commands follow one per cycle
//   while rsp_stall is low, num_digits commands per item
// items do not overlap: req_stall stays high through the bit-serial bcd conversion and
//   the one-digit-per-cycle command sequencer, until the last command is issued
// reset: synchronous, active high; configuration returns to 3 digits, point 2, sign limit 3
`timescale 1ns / 1ps
module signed_int_to_segment_commands #(
   parameter int MAX_DIGITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [sisc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sisc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [sisc_pkg::MAG_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sisc_pkg::IDX_W-1:0]        rsp_digit_address,
   output logic [sisc_pkg::SEG_W-1:0]        rsp_segment_data,
   output logic                              rsp_last
);
   import sisc_pkg::*;

   logic [ND_W-1:0]  num_digits_ff, num_digits_in;
   logic [PP_W-1:0]  point_pos_ff, point_pos_in;
   logic [SL_W-1:0]  sign_limit_ff, sign_limit_in;
   logic             neg_ff, neg_in;
   state_type        state_ff, state_in;

   logic             accept;
   logic             bcd_start;
   logic             emit_start;
   logic [MAG_W-1:0] magnitude;
   logic [4*MAX_DIGITS-1:0] bcd;
   bcd_status_type   bcd_status;
   emit_ctrl_type    emit_ctrl;
   emit_status_type  emit_status;
   logic [IDX_W-1:0] nd_eff;
   logic [IDX_W-1:0] pp_ext;

   // configuration writes
   always_comb begin
      num_digits_in = num_digits_ff;
      point_pos_in  = point_pos_ff;
      sign_limit_in = sign_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_DIGITS:     num_digits_in = csr_wdata[ND_W-1:0];
            CSR_POINT_POSITION: point_pos_in  = csr_wdata[PP_W-1:0];
            CSR_SIGN_LIMIT:     sign_limit_in = csr_wdata[SL_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp digit count to one..MAX_DIGITS and widen the point; it is clamped below the count at emit_ctrl
   always_comb begin
      priority if (num_digits_ff == '0) begin
         nd_eff = IDX_W'(1);
      end else if ({1'b0, num_digits_ff} > IDX_W'(MAX_DIGITS)) begin
         nd_eff = IDX_W'(MAX_DIGITS);
      end else begin
         nd_eff = {1'b0, num_digits_ff};
      end
      pp_ext = {1'b0, point_pos_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_CONVERT;
         ST_CONVERT: if (bcd_status.done) state_in = ST_EMIT;
         ST_EMIT:    if (!emit_status.busy) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall  = 1'b1;
      bcd_start  = 1'b0;
      emit_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            bcd_start = req_valid;
         end
         ST_CONVERT: emit_start = bcd_status.done;
         ST_EMIT:    ;
         default:    ;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign neg_in    = accept ? req_value[MAG_W-1] : neg_ff;
   assign magnitude = req_value[MAG_W-1] ? (MAG_W'(0) - MAG_W'(req_value)) : MAG_W'(req_value);

   assign emit_ctrl.start      = emit_start;
   assign emit_ctrl.neg        = neg_ff;
   assign emit_ctrl.sticky     = bcd_status.sticky;
   assign emit_ctrl.num_digits = nd_eff;
   assign emit_ctrl.point_pos  = (pp_ext > nd_eff - 1'b1) ? nd_eff - 1'b1 : pp_ext;
   assign emit_ctrl.sign_limit = sign_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_digits_ff <= NUM_DIGITS_RESET;
         point_pos_ff  <= POINT_POSITION_RESET;
         sign_limit_ff <= SIGN_LIMIT_RESET;
         state_ff      <= ST_IDLE;
      end else begin
         num_digits_ff <= num_digits_in;
         point_pos_ff  <= point_pos_in;
         sign_limit_ff <= sign_limit_in;
         state_ff      <= state_in;
      end
      neg_ff <= neg_in;
   end

   sisc_bcd #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (bcd_start),
      .magnitude (magnitude),
      .bcd       (bcd),
      .status    (bcd_status)
   );

   sisc_emit #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (emit_ctrl),
      .bcd               (bcd),
      .status            (emit_status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digit_address (rsp_digit_address),
      .rsp_segment_data  (rsp_segment_data),
      .rsp_last          (rsp_last)
   );

endmodule
